// ----- sv/gcc_pkg.sv -----
// Shared types, constants and command codes of the graph colinear chaining block.
package gcc_pkg;

  localparam int NODE_W   = 10;
  localparam int POS_BITS = 20;
  localparam int SCORE_W  = POS_BITS + 1;
  localparam int STAMP_W  = 7;
  localparam int NC_W     = 17;
  localparam int CNT_W    = 11;

  localparam int DEF_MAX_NODES   = 1024;
  localparam int DEF_MAX_EDGES   = 4096;
  localparam int DEF_MAX_ANCHORS = 64;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_EDGE   = 2'd1;
  localparam logic [1:0] MODE_ANCHOR = 2'd2;
  localparam logic [1:0] MODE_RUN    = 2'd3;

  localparam logic [1:0] GOP_CLEAR  = 2'd0;
  localparam logic [1:0] GOP_ADD    = 2'd1;
  localparam logic [1:0] GOP_STCLR  = 2'd2;
  localparam logic [1:0] GOP_WALK   = 2'd3;

  typedef struct packed {
    logic [NODE_W-1:0]   start_node;
    logic [NODE_W-1:0]   end_node;
    logic [POS_BITS-1:0] x;
    logic [POS_BITS-1:0] y;
  } anchor_t;

  typedef struct packed {
    logic                start;
    logic [1:0]          op;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [STAMP_W-1:0]  stamp;
    logic [NODE_W-1:0]   q_node;
    logic [NC_W-1:0]     nc;
  } gcmd_t;

  typedef struct packed {
    logic               busy;
    logic [STAMP_W-1:0] stamp;
  } gstat_t;

endpackage

// ----- sv/gcc_graph.sv -----
// Edge store, visit stamps and breadth-first walk sequencer.
module gcc_graph #(
  parameter int MAX_NODES = gcc_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = gcc_pkg::DEF_MAX_EDGES
) (
  input  logic           clk,
  input  logic           rst,
  input  gcc_pkg::gcmd_t cmd,
  output gcc_pkg::gstat_t stat
);
  localparam int NW = $clog2(MAX_NODES);
  localparam int EW = $clog2(MAX_EDGES + 1);
  localparam int SW = gcc_pkg::STAMP_W;
  localparam int VW = gcc_pkg::NODE_W;

  localparam logic [3:0] G_IDLE = 4'd0;
  localparam logic [3:0] G_CLR  = 4'd1;
  localparam logic [3:0] G_SCLR = 4'd2;
  localparam logic [3:0] G_ADD  = 4'd3;
  localparam logic [3:0] W_POP  = 4'd4;
  localparam logic [3:0] W_U    = 4'd5;
  localparam logic [3:0] W_E    = 4'd6;
  localparam logic [3:0] W_CHK  = 4'd7;
  localparam logic [3:0] W_V    = 4'd8;
  localparam logic [3:0] W_S    = 4'd9;

  localparam logic [1:0] GOP_WALK_C = gcc_pkg::GOP_WALK;

  logic [3:0]    state;
  logic [NW-1:0] cnt;
  logic [EW-1:0] edge_total;
  logic [VW-1:0] from_r, to_r, v;
  logic [EW-1:0] e;
  logic [NW:0]   qh, tail;
  logic [SW-1:0] wstamp;
  logic [gcc_pkg::NC_W-1:0] nc_r;

  logic [EW-1:0] head_mem [MAX_NODES];
  logic [EW-1:0] next_mem [MAX_EDGES+1];
  logic [VW-1:0] tgt_mem  [MAX_EDGES+1];
  logic [SW-1:0] stamp_mem [MAX_NODES];
  logic [VW-1:0] queue_mem [MAX_NODES];

  logic [EW-1:0] head_rd, next_rd;
  logic [VW-1:0] tgt_rd, queue_rd;
  logic [SW-1:0] stamp_rd;

  logic [NW-1:0] head_ra, head_wa, stamp_ra, stamp_wa, queue_wa;
  logic [EW-1:0] head_wd, edge_wa;
  logic [SW-1:0] stamp_wd;
  logic [VW-1:0] queue_wd;
  logic          head_we, edge_we, stamp_we, queue_we;
  logic          walk_ok, src_ok, take;
  logic [EW-1:0] e_new;

  assign e_new   = edge_total + EW'(1);
  assign src_ok  = gcc_pkg::NC_W'(cmd.node_a) < cmd.nc;
  assign walk_ok = (state == G_IDLE) && cmd.start && (cmd.op == GOP_WALK_C) && src_ok;
  assign take    = (gcc_pkg::NC_W'(v) < nc_r) && (stamp_rd != wstamp) &&
                   (tail < (NW+1)'(MAX_NODES));

  always_comb begin
    head_ra  = NW'(cmd.node_a);
    stamp_ra = NW'(cmd.q_node);
    head_we  = 1'b0;
    head_wa  = NW'(from_r);
    head_wd  = e_new;
    edge_we  = 1'b0;
    edge_wa  = e_new;
    stamp_we = 1'b0;
    stamp_wa = NW'(v);
    stamp_wd = wstamp;
    queue_we = 1'b0;
    queue_wa = tail[NW-1:0];
    queue_wd = v;
    case (state)
      G_CLR: begin
        head_we = 1'b1;
        head_wa = cnt;
        head_wd = '0;
      end
      G_SCLR: begin
        stamp_we = 1'b1;
        stamp_wa = cnt;
        stamp_wd = '0;
      end
      G_ADD: begin
        if (edge_total < EW'(MAX_EDGES)) begin
          head_we = 1'b1;
          edge_we = 1'b1;
        end
      end
      W_U: head_ra = NW'(queue_rd);
      W_V: stamp_ra = NW'(tgt_rd);
      W_S: begin
        stamp_we = take;
        queue_we = take;
      end
      default: ;
    endcase
    if (walk_ok) begin
      stamp_we = 1'b1;
      stamp_wa = NW'(cmd.node_a);
      stamp_wd = cmd.stamp;
      queue_we = 1'b1;
      queue_wa = '0;
      queue_wd = cmd.node_a;
    end
  end

  always_ff @(posedge clk) begin
    head_rd  <= head_mem[head_ra];
    if (head_we) head_mem[head_wa] <= head_wd;
    next_rd  <= next_mem[e];
    tgt_rd   <= tgt_mem[e];
    if (edge_we) begin
      next_mem[edge_wa] <= head_rd;
      tgt_mem[edge_wa]  <= to_r;
    end
    stamp_rd <= stamp_mem[stamp_ra];
    if (stamp_we) stamp_mem[stamp_wa] <= stamp_wd;
    queue_rd <= queue_mem[qh[NW-1:0]];
    if (queue_we) queue_mem[queue_wa] <= queue_wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= G_CLR;
      cnt        <= '0;
      edge_total <= '0;
    end else begin
      case (state)
        G_IDLE: begin
          cnt <= '0;
          if (cmd.start) begin
            from_r <= cmd.node_a;
            to_r   <= cmd.node_b;
            wstamp <= cmd.stamp;
            nc_r   <= cmd.nc;
            qh     <= '0;
            tail   <= src_ok ? (NW+1)'(1) : '0;
            case (cmd.op)
              gcc_pkg::GOP_CLEAR: begin
                state      <= G_CLR;
                edge_total <= '0;
              end
              gcc_pkg::GOP_ADD:   state <= G_ADD;
              gcc_pkg::GOP_STCLR: state <= G_SCLR;
              default:            state <= W_POP;
            endcase
          end
        end
        G_CLR, G_SCLR: begin
          cnt <= cnt + NW'(1);
          if (cnt == NW'(MAX_NODES - 1)) state <= G_IDLE;
        end
        G_ADD: begin
          if (edge_total < EW'(MAX_EDGES)) edge_total <= e_new;
          state <= G_IDLE;
        end
        W_POP: begin
          if (qh == tail) begin
            state <= G_IDLE;
          end else begin
            qh    <= qh + (NW+1)'(1);
            state <= W_U;
          end
        end
        W_U: state <= W_E;
        W_E: begin
          e     <= head_rd;
          state <= W_CHK;
        end
        W_CHK: begin
          if (e == '0 || e > edge_total) state <= W_POP;
          else state <= W_V;
        end
        W_V: begin
          v     <= tgt_rd;
          e     <= next_rd;
          state <= W_S;
        end
        W_S: begin
          if (take) tail <= tail + (NW+1)'(1);
          state <= W_CHK;
        end
        default: state <= G_IDLE;
      endcase
    end
  end

  assign stat.busy  = (state != G_IDLE);
  assign stat.stamp = stamp_rd;

endmodule

// ----- sv/graph_colinear_chaining_top.sv -----
// Load: an anchor is stored as it is accepted; a clear or a valid edge waits in S_GWAIT for the graph.
// Run: clears the score/predecessor and stamp memories, ranks the anchors by (y, x), then per
// anchor in rank order walks the graph from its end node and scans every anchor as a successor.
// Results leave one word at a time through an output register, each held until m_tready.
// Reset (synchronous, active high) sweeps the edge heads, input not ready.
// One item is worked on at a time; the edge/stamp memory ports set the pace of a run.
module graph_colinear_chaining_top #(
  parameter int MAX_NODES   = gcc_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES   = gcc_pkg::DEF_MAX_EDGES,
  parameter int MAX_ANCHORS = gcc_pkg::DEF_MAX_ANCHORS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data,   // node_count
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,    // edge_from, edge_to, start_node, end_node, read_begin, read_end
  input  logic [1:0]  s_tuser,    // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,    // anchor_index, anchor_score, best_coverage
  output logic [0:0]  m_tuser,    // no_chain
  output logic        m_tlast
);
  localparam int AW  = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;
  localparam int PB  = gcc_pkg::POS_BITS;
  localparam int SCW = gcc_pkg::SCORE_W;
  localparam int NCW = gcc_pkg::NC_W;
  localparam int VW  = gcc_pkg::NODE_W;

  localparam logic [4:0] S_GWAIT  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_RCLR   = 5'd2;
  localparam logic [4:0] S_SCLR   = 5'd3;
  localparam logic [4:0] S_SWAIT  = 5'd4;
  localparam logic [4:0] S_RK_I   = 5'd5;
  localparam logic [4:0] S_RK_IL  = 5'd6;
  localparam logic [4:0] S_RK_J   = 5'd7;
  localparam logic [4:0] S_RK_JU  = 5'd8;
  localparam logic [4:0] S_M_ORD  = 5'd9;
  localparam logic [4:0] S_M_ORD2 = 5'd10;
  localparam logic [4:0] S_M_OWN  = 5'd11;
  localparam logic [4:0] S_M_WALK = 5'd12;
  localparam logic [4:0] S_M_J    = 5'd13;
  localparam logic [4:0] S_M_J2   = 5'd14;
  localparam logic [4:0] S_M_J3   = 5'd15;
  localparam logic [4:0] S_M_BEST = 5'd16;
  localparam logic [4:0] S_C_RD   = 5'd17;
  localparam logic [4:0] S_C_PRED = 5'd18;
  localparam logic [4:0] S_E_RD   = 5'd19;
  localparam logic [4:0] S_E_SC   = 5'd20;
  localparam logic [4:0] S_E_OUT  = 5'd21;
  localparam logic [4:0] S_EMPTY  = 5'd22;

  logic [4:0]   state;
  logic [10:0]  node_count;
  logic [AW:0]  anchor_total, i, j, k, rank, len, ek, cj;
  logic [AW-1:0] cnt, ai_idx, best_i, eidx;
  logic [2*PB-1:0] key_i;
  logic [PB-1:0]   ay;
  logic [SCW-1:0]  si, best_s;

  logic [NCW-1:0] nc;
  gcc_pkg::gcmd_t  gcmd;
  gcc_pkg::gstat_t gst;

  gcc_pkg::anchor_t anc_mem [MAX_ANCHORS];
  logic [SCW-1:0]   score_mem [MAX_ANCHORS];
  logic [AW:0]      pred_mem [MAX_ANCHORS];
  logic [AW-1:0]    order_mem [MAX_ANCHORS];
  logic [AW-1:0]    chain_mem [MAX_ANCHORS];

  gcc_pkg::anchor_t anc_rd, anc_wd;
  logic [SCW-1:0]   score_rd, score_wd;
  logic [AW:0]      pred_rd, pred_wd;
  logic [AW-1:0]    order_rd, chain_rd;
  logic [AW-1:0]    anc_ra, sp_ra, sp_wa, chain_ra;
  logic             anc_we, sp_we, order_we, chain_we;

  logic [VW-1:0] in_from, in_to, in_start, in_end;
  logic [PB-1:0] in_x, in_y;
  logic          accept, from_ok, to_ok, out_free, emit;
  logic          lt, last_j;
  logic [AW:0]   rank_inc;
  logic [SCW-1:0] own;
  logic [PB-1:0]  lo;
  logic [PB+2:0]  value;
  logic           reach, better;

  assign in_from  = s_tdata[9:0];
  assign in_to    = s_tdata[19:10];
  assign in_start = s_tdata[29:20];
  assign in_end   = s_tdata[39:30];
  assign in_x     = s_tdata[59:40];
  assign in_y     = s_tdata[79:60];

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign emit      = out_free && ((state == S_E_OUT) || (state == S_EMPTY));

  assign nc = (NCW'(node_count) > NCW'(MAX_NODES)) ? NCW'(MAX_NODES) : NCW'(node_count);
  assign from_ok = NCW'(in_from) < nc;
  assign to_ok   = NCW'(in_to) < nc;

  assign lt       = {anc_rd.y, anc_rd.x, j[AW-1:0]} < {key_i, i[AW-1:0]};
  assign rank_inc = rank + (AW+1)'(lt);
  assign last_j   = (j + (AW+1)'(1)) == anchor_total;

  assign own = (anc_rd.y >= anc_rd.x) ? (SCW'(anc_rd.y) - SCW'(anc_rd.x) + SCW'(1)) : '0;
  assign lo  = (anc_rd.x != '0 && (anc_rd.x - PB'(1)) > ay) ? (anc_rd.x - PB'(1)) : ay;
  assign value = (PB+3)'(si) + (PB+3)'(anc_rd.y) - (PB+3)'(lo);
  assign reach = (NCW'(anc_rd.start_node) < nc) &&
                 (gst.stamp == gcc_pkg::STAMP_W'(k + (AW+1)'(1)));
  assign better = reach && (anc_rd.y > ay) && !value[PB+2] &&
                  (value[PB+1:0] > (PB+2)'(score_rd));

  // graph commands
  always_comb begin
    gcmd        = '0;
    gcmd.node_a = in_from;
    gcmd.node_b = in_to;
    gcmd.q_node = anc_rd.start_node;
    gcmd.nc     = nc;
    gcmd.stamp  = gcc_pkg::STAMP_W'(k + (AW+1)'(1));
    case (state)
      S_IDLE: begin
        if (accept && s_tuser == gcc_pkg::MODE_CLEAR) begin
          gcmd.start = 1'b1;
          gcmd.op    = gcc_pkg::GOP_CLEAR;
        end else if (accept && s_tuser == gcc_pkg::MODE_EDGE && from_ok && to_ok) begin
          gcmd.start = 1'b1;
          gcmd.op    = gcc_pkg::GOP_ADD;
        end
      end
      S_SCLR: begin
        gcmd.start = 1'b1;
        gcmd.op    = gcc_pkg::GOP_STCLR;
      end
      S_M_OWN: begin
        gcmd.start  = 1'b1;
        gcmd.op     = gcc_pkg::GOP_WALK;
        gcmd.node_a = anc_rd.end_node;
      end
      default: ;
    endcase
  end

  gcc_graph #(
    .MAX_NODES(MAX_NODES),
    .MAX_EDGES(MAX_EDGES)
  ) u_graph (
    .clk (clk),
    .rst (rst),
    .cmd (gcmd),
    .stat(gst)
  );

  // memory address and write selection
  always_comb begin
    anc_ra   = j[AW-1:0];
    sp_ra    = j[AW-1:0];
    chain_ra = AW'(len - ek - (AW+1)'(1));
    anc_we   = accept && (s_tuser == gcc_pkg::MODE_ANCHOR) &&
               (anchor_total < (AW+1)'(MAX_ANCHORS));
    anc_wd   = '{start_node: in_start, end_node: in_end, x: in_x, y: in_y};
    sp_we    = 1'b0;
    sp_wa    = j[AW-1:0];
    score_wd = value[SCW-1:0];
    pred_wd  = (AW+1)'(ai_idx) + (AW+1)'(1);
    order_we = (state == S_RK_JU) && last_j;
    chain_we = (state == S_C_RD) && (cj != '0) && (len != anchor_total);
    case (state)
      S_RCLR: begin
        sp_we    = 1'b1;
        sp_wa    = cnt;
        score_wd = '0;
        pred_wd  = '0;
      end
      S_RK_I: anc_ra = i[AW-1:0];
      S_M_ORD2: begin
        anc_ra = order_rd;
        sp_ra  = order_rd;
      end
      S_M_OWN: begin
        anc_ra = ai_idx;
        sp_ra  = ai_idx;
        if (own > score_rd) begin
          sp_we    = 1'b1;
          sp_wa    = ai_idx;
          score_wd = own;
          pred_wd  = '0;
        end
      end
      S_M_J3: sp_we = better;
      S_C_RD, S_C_PRED: sp_ra = AW'(cj - (AW+1)'(1));
      S_E_SC: sp_ra = chain_rd;
      S_E_OUT: sp_ra = eidx;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    anc_rd <= anc_mem[anc_ra];
    if (anc_we) anc_mem[anchor_total[AW-1:0]] <= anc_wd;
    score_rd <= score_mem[sp_ra];
    pred_rd  <= pred_mem[sp_ra];
    if (sp_we) begin
      score_mem[sp_wa] <= score_wd;
      pred_mem[sp_wa]  <= pred_wd;
    end
    order_rd <= order_mem[k[AW-1:0]];
    if (order_we) order_mem[rank_inc[AW-1:0]] <= i[AW-1:0];
    chain_rd <= chain_mem[chain_ra];
    if (chain_we) chain_mem[len[AW-1:0]] <= AW'(cj - (AW+1)'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_GWAIT;
      node_count   <= 11'd1024;
      anchor_total <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid) node_count <= cfg_data;
      if (emit) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        S_GWAIT: if (!gst.busy) state <= S_IDLE;
        S_IDLE: begin
          cnt <= '0;
          if (accept) begin
            case (s_tuser)
              gcc_pkg::MODE_CLEAR: begin
                anchor_total <= '0;
                state        <= S_GWAIT;
              end
              gcc_pkg::MODE_EDGE: if (from_ok && to_ok) state <= S_GWAIT;
              gcc_pkg::MODE_ANCHOR: begin
                if (anchor_total < (AW+1)'(MAX_ANCHORS))
                  anchor_total <= anchor_total + (AW+1)'(1);
              end
              default: state <= (anchor_total == '0) ? S_EMPTY : S_RCLR;
            endcase
          end
        end
        S_RCLR: begin
          cnt <= cnt + AW'(1);
          if (cnt == AW'(MAX_ANCHORS - 1)) state <= S_SCLR;
        end
        S_SCLR: state <= S_SWAIT;
        S_SWAIT: begin
          if (!gst.busy) begin
            i      <= '0;
            j      <= '0;
            k      <= '0;
            rank   <= '0;
            best_s <= '0;
            best_i <= '0;
            state  <= S_RK_I;
          end
        end
        S_RK_I: state <= S_RK_IL;
        S_RK_IL: begin
          key_i <= {anc_rd.y, anc_rd.x};
          j     <= '0;
          state <= S_RK_J;
        end
        S_RK_J: state <= S_RK_JU;
        S_RK_JU: begin
          if (last_j) begin
            rank <= '0;
            i    <= i + (AW+1)'(1);
            if ((i + (AW+1)'(1)) == anchor_total) state <= S_M_ORD;
            else state <= S_RK_I;
          end else begin
            rank  <= rank_inc;
            j     <= j + (AW+1)'(1);
            state <= S_RK_J;
          end
        end
        S_M_ORD: state <= S_M_ORD2;
        S_M_ORD2: begin
          ai_idx <= order_rd;
          state  <= S_M_OWN;
        end
        S_M_OWN: begin
          ay    <= anc_rd.y;
          si    <= (own > score_rd) ? own : score_rd;
          state <= S_M_WALK;
        end
        S_M_WALK: begin
          if (!gst.busy) begin
            j     <= '0;
            state <= S_M_J;
          end
        end
        S_M_J:  state <= S_M_J2;
        S_M_J2: state <= S_M_J3;
        S_M_J3: begin
          j     <= j + (AW+1)'(1);
          state <= last_j ? S_M_BEST : S_M_J;
        end
        S_M_BEST: begin
          if (si > best_s || (si == best_s && ai_idx > best_i)) begin
            best_s <= si;
            best_i <= ai_idx;
          end
          k <= k + (AW+1)'(1);
          if ((k + (AW+1)'(1)) == anchor_total) begin
            cj    <= (si > best_s || (si == best_s && ai_idx > best_i)) ?
                     (AW+1)'(ai_idx) + (AW+1)'(1) : (AW+1)'(best_i) + (AW+1)'(1);
            len   <= '0;
            state <= S_C_RD;
          end else begin
            state <= S_M_ORD;
          end
        end
        S_C_RD: begin
          if (cj == '0 || len == anchor_total) begin
            ek    <= '0;
            state <= S_E_RD;
          end else begin
            len   <= len + (AW+1)'(1);
            state <= S_C_PRED;
          end
        end
        S_C_PRED: begin
          cj    <= pred_rd;
          state <= S_C_RD;
        end
        S_E_RD: state <= S_E_SC;
        S_E_SC: begin
          eidx  <= chain_rd;
          state <= S_E_OUT;
        end
        S_E_OUT: begin
          if (out_free) begin
            m_tdata  <= {best_s, score_rd, 6'(eidx)};
            m_tuser  <= 1'b0;
            m_tlast  <= (ek + (AW+1)'(1)) == len;
            ek       <= ek + (AW+1)'(1);
            state    <= ((ek + (AW+1)'(1)) == len) ? S_IDLE : S_E_RD;
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            m_tdata  <= '0;
            m_tuser  <= 1'b1;
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/gcc_check.sv -----
// Port-level checks of the chaining block, bound to the top level.
module gcc_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [0:0]  m_tuser,
  input logic        m_tlast
);

  a_reset_sweep: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input ready right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output word dropped while stalled");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == 48'd0))
    else $error("no-chain word malformed");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == gcc_pkg::MODE_RUN) |=> !s_tready)
    else $error("input taken during run");

endmodule

bind graph_colinear_chaining_top gcc_check u_gcc_check (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tuser (s_tuser),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);
